>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DVCS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dvcs assertion failed");

// Clocked assertion that also holds across reset.
`define DVCS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("dvcs assertion failed");

`endif

>>> sv/dvcs_pkg.sv
// ----------------------------------------------------------------------------
// dvcs_pkg
// Types and constants of the sorted distinct value collector.
// ----------------------------------------------------------------------------
`default_nettype none

package dvcs_pkg;

   localparam int VALUE_W     = 16;
   localparam int KEY_W       = 16;
   localparam int KIND_W      = 8;
   localparam int SET_COUNT_W = 7;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 2;

   // rsp_tuser bit positions
   localparam int RSP_USER_EMPTY = 0;
   localparam int RSP_USER_OVF   = 1;

   localparam logic [KIND_W-1:0]  KIND_COLLECT = 8'h12;
   localparam logic [VALUE_W-1:0] NO_VALUE     = 16'hFFFF;

   // request kind carried on req_tuser
   localparam logic REQ_RECORD = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   // queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef struct packed {
      logic               finish;
      logic [VALUE_W-1:0] value;
   } queue_entry_type;

   typedef struct packed {
      logic [VALUE_W-1:0]     value;
      logic [SET_COUNT_W-1:0] count;
      logic                   last;
      logic                   empty;
      logic                   ovf;
   } rsp_beat_type;

endpackage

`default_nettype wire

>>> sv/dvcs_fifo.sv
// ----------------------------------------------------------------------------
// dvcs_fifo
// Short queue of classified requests between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dvcs_fifo (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  dvcs_pkg::queue_entry_type  push_entry,
   output logic                       full,
   input  wire                        pop,
   output dvcs_pkg::queue_entry_type  head_entry,
   output logic                       not_empty
);

   dvcs_pkg::queue_entry_type entry_ff [dvcs_pkg::QDEPTH];

   logic [dvcs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dvcs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dvcs_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic                        do_push;
   logic                        do_pop;

   assign full       = (cnt_ff == dvcs_pkg::QCNT_W'(dvcs_pkg::QDEPTH));
   assign not_empty  = (cnt_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> sv/dvcs_front.sv
// ----------------------------------------------------------------------------
// dvcs_front
// Accepts request beats, holds the match key and filters records; kept
// values and finish requests go to the queue, the rest is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module dvcs_front (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     csr_wr_en,
   input  wire  [dvcs_pkg::KEY_W-1:0]              csr_wr_data,
   input  wire                                     req_tvalid,
   output logic                                    req_tready,
   input  wire  [dvcs_pkg::REQ_TDATA_W-1:0]        req_tdata,
   input  wire                                     req_tuser,
   input  wire                                     q_full,
   output logic                                    q_push,
   output dvcs_pkg::queue_entry_type               q_entry
);

   logic [dvcs_pkg::KEY_W-1:0]   match_key_ff, match_key_in;
   logic [dvcs_pkg::KIND_W-1:0]  rec_kind;
   logic [dvcs_pkg::KEY_W-1:0]   rec_key;
   logic [dvcs_pkg::VALUE_W-1:0] rec_value;
   logic                         is_finish;
   logic                         keep;

   assign rec_kind  = req_tdata[7:0];
   assign rec_key   = req_tdata[23:8];
   assign rec_value = req_tdata[39:24];
   assign is_finish = (req_tuser == dvcs_pkg::REQ_FINISH);

   assign keep = (rec_kind == dvcs_pkg::KIND_COLLECT)
              && (rec_key == match_key_ff)
              && (rec_value != dvcs_pkg::NO_VALUE);

   assign req_tready     = !q_full;
   assign q_push         = req_tvalid && !q_full && (is_finish || keep);
   assign q_entry.finish = is_finish;
   assign q_entry.value  = rec_value;

   assign match_key_in = csr_wr_en ? csr_wr_data : match_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_key_ff <= '0;
      end else begin
         match_key_ff <= match_key_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/dvcs_back.sv
// ----------------------------------------------------------------------------
// dvcs_back
// Sorted set engine: binary search for the insert point, shift-up insert
// through a memory with one read and one write port, and in-order readout on finish.
// ----------------------------------------------------------------------------
`default_nettype none

module dvcs_back #(
   parameter int CAPACITY = 64
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        q_valid,
   input  dvcs_pkg::queue_entry_type  q_entry,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output dvcs_pkg::rsp_beat_type     rsp_beat
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DECIDE,
      S_SHIFT,
      S_PLACE,
      S_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic                         ovf_ff, ovf_in;
   logic [dvcs_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [CW-1:0]                lo_ff, lo_in;
   logic [CW-1:0]                hi_ff, hi_in;
   logic [AW-1:0]                mid_ff, mid_in;
   logic                         found_ff, found_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic                         out_valid_ff, out_valid_in;
   dvcs_pkg::rsp_beat_type       out_beat_ff, out_beat_in;

   logic [dvcs_pkg::VALUE_W-1:0] mem [CAPACITY];
   logic [dvcs_pkg::VALUE_W-1:0] rd_data_ff;
   logic [AW-1:0]                rd_addr;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [dvcs_pkg::VALUE_W-1:0] wr_data;

   logic                         out_free;
   logic [CW:0]                  mid_sum;
   logic [AW-1:0]                mid_calc;
   logic [CW-1:0]                mid_ext;
   logic                         probe_lt;
   logic                         probe_eq;
   logic [CW-1:0]                lo_step;
   logic [CW-1:0]                hi_step;
   logic [CW-1:0]                count_m1;
   logic [CW-1:0]                idx_m1;
   logic [CW-1:0]                idx_m2;
   logic [CW-1:0]                idx_p1;
   logic                         set_full;
   logic [CW+6:0]                count_wide;
   logic [dvcs_pkg::SET_COUNT_W-1:0] count7;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc   = mid_sum[AW:1];
   assign mid_ext    = CW'(mid_ff);
   assign probe_lt   = (rd_data_ff < val_ff);
   assign probe_eq   = (rd_data_ff == val_ff);
   assign lo_step    = probe_lt ? mid_ext + 1'b1 : lo_ff;
   assign hi_step    = probe_lt ? hi_ff : mid_ext;
   assign count_m1   = count_ff - 1'b1;
   assign idx_m1     = idx_ff - 1'b1;
   assign idx_m2     = idx_ff - CW'(2);
   assign idx_p1     = idx_ff + 1'b1;
   assign set_full   = (count_ff == CW'(CAPACITY));
   // set_count is the held count masked to its field width
   assign count_wide = {7'd0, count_ff};
   assign count7     = count_wide[dvcs_pkg::SET_COUNT_W-1:0];

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_beat_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      val_in       = val_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_beat_in  = out_beat_ff;
      q_pop        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = lo_ff[AW-1:0];
      wr_data      = val_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (q_entry.finish) begin
                  if (count_ff == '0) begin
                     if (out_free) begin
                        q_pop              = 1'b1;
                        out_valid_in       = 1'b1;
                        out_beat_in.value  = '0;
                        out_beat_in.count  = '0;
                        out_beat_in.last   = 1'b1;
                        out_beat_in.empty  = 1'b1;
                        out_beat_in.ovf    = ovf_ff;
                        ovf_in             = 1'b0;
                     end
                  end else begin
                     q_pop    = 1'b1;
                     idx_in   = '0;
                     rd_addr  = '0;
                     state_in = S_EMIT;
                  end
               end else begin
                  q_pop    = 1'b1;
                  val_in   = q_entry.value;
                  lo_in    = '0;
                  hi_in    = count_ff;
                  found_in = 1'b0;
                  state_in = (count_ff == '0) ? S_DECIDE : S_SRCH_RD;
               end
            end
         end
         S_SRCH_RD: begin
            rd_addr  = mid_calc;
            mid_in   = mid_calc;
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            lo_in    = lo_step;
            hi_in    = hi_step;
            found_in = found_ff || probe_eq;
            state_in = (lo_step == hi_step) ? S_DECIDE : S_SRCH_RD;
         end
         S_DECIDE: begin
            if (found_ff) begin
               state_in = S_IDLE;
            end else if (set_full) begin
               ovf_in   = 1'b1;
               state_in = S_IDLE;
            end else if (count_ff == lo_ff) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_addr  = count_m1[AW-1:0];
               idx_in   = count_ff;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // move one entry up per cycle, reading the next one below
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data_ff;
            idx_in  = idx_m1;
            if (idx_m1 == lo_ff) begin
               state_in = S_PLACE;
            end else begin
               rd_addr = idx_m2[AW-1:0];
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = S_IDLE;
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in      = 1'b1;
               out_beat_in.value = rd_data_ff;
               out_beat_in.count = count7;
               out_beat_in.last  = (idx_p1 == count_ff);
               out_beat_in.empty = 1'b0;
               out_beat_in.ovf   = ovf_ff;
               if (idx_p1 == count_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  idx_in  = idx_p1;
                  rd_addr = idx_p1[AW-1:0];
               end
            end else begin
               rd_addr = idx_ff[AW-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
      val_ff      <= val_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      found_ff    <= found_in;
      idx_ff      <= idx_in;
      out_beat_ff <= out_beat_in;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

`default_nettype wire

>>> sv/distinct_value_collect_sort.sv
// ----------------------------------------------------------------------------
// distinct_value_collect_sort
// Collects distinct matching record values into a sorted set and streams
// the set out in ascending order on a finish request.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  req_     in   tdata: rec_kind, rec_key, rec_value; tuser: req_type
//  rsp_     out  tdata: out_value, set_count; tlast: last_value;
//                tuser: set_empty, overflowed
//  csr_     in   match_key write, no read-back
//
//  A dropped record never enters the queue. A kept record is placed by a
//  binary search in the set engine; when it lands below the top of the set,
//  the values above it are shifted up one at a time through the value
//  memory, which has one read and one write port. A finish with n values
//  gives one beat per cycle while rsp_tready is high.
//  A four-beat queue decouples intake from the set engine, so req_ stalls
//  only when it is full. Reset is synchronous; the memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_value_collect_sort #(
   parameter int CAPACITY = 64
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_wr_en,
   input  wire  [dvcs_pkg::KEY_W-1:0]           csr_wr_data,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // [7:0] rec_kind, [23:8] rec_key, [39:24] rec_value
   input  wire  [dvcs_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] req_type
   input  wire                                  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // [15:0] out_value, [22:16] set_count, [23] zero
   output logic [dvcs_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   // [0] set_empty, [1] overflowed
   output logic [dvcs_pkg::RSP_TUSER_W-1:0]     rsp_tuser
);

   logic                      q_push;
   logic                      q_full;
   logic                      q_pop;
   logic                      q_not_empty;
   dvcs_pkg::queue_entry_type q_in_entry;
   dvcs_pkg::queue_entry_type q_head;
   dvcs_pkg::rsp_beat_type    beat;

   dvcs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_in_entry)
   );

   dvcs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_entry (q_head),
      .not_empty  (q_not_empty)
   );

   dvcs_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_entry   (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_beat  (beat)
   );

   assign rsp_tdata = {1'b0, beat.count, beat.value};
   assign rsp_tlast = beat.last;
   assign rsp_tuser = {beat.ovf, beat.empty};

endmodule

`default_nettype wire

>>> sv/dvcs_checker.sv
// ----------------------------------------------------------------------------
// dvcs_checker
// Port-level checks on the result channel of the collector.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dvcs_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [dvcs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input wire                                rsp_tlast,
   input wire [dvcs_pkg::RSP_TUSER_W-1:0]    rsp_tuser
);

   `DVCS_ASSERT(a_hold_valid, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `DVCS_ASSERT(a_hold_beat, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
   // an empty finish is a single beat that closes the run
   `DVCS_ASSERT(a_empty_last, clock, reset, rsp_tvalid && rsp_tuser[dvcs_pkg::RSP_USER_EMPTY] |-> rsp_tlast)
   `DVCS_ASSERT(a_empty_zero, clock, reset, rsp_tvalid && rsp_tuser[dvcs_pkg::RSP_USER_EMPTY] |-> rsp_tdata == '0)
   `DVCS_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_tvalid)

endmodule

bind distinct_value_collect_sort dvcs_checker u_dvcs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
